// ===== src/twa_pkg.sv =====
// ----------------------------------------------------------------------------
// twa_pkg
// Shared widths, codes and word layouts of the time-weighted accumulator.
// ----------------------------------------------------------------------------
package twa_pkg;

    // Field widths
    localparam int IDX_W   = 10;
    localparam int VALUE_W = 32;
    localparam int TIME_W  = 48;
    localparam int DUR_W   = 32;
    localparam int MODE_W  = 2;

    // Input word: cell_index, sample_value, step_duration from bit 0 up
    localparam int IN_IDX_LSB  = 0;
    localparam int IN_SMP_LSB  = IN_IDX_LSB + IDX_W;
    localparam int IN_DUR_LSB  = IN_SMP_LSB + VALUE_W;
    localparam int IN_BITS     = IN_DUR_LSB + DUR_W;
    localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;

    // Output word: out_index, accumulated_value, accumulated_time,
    // time_saturated from bit 0 up
    localparam int OUT_IDX_LSB  = 0;
    localparam int OUT_VAL_LSB  = OUT_IDX_LSB + IDX_W;
    localparam int OUT_TIME_LSB = OUT_VAL_LSB + VALUE_W;
    localparam int OUT_SAT_BIT  = OUT_TIME_LSB + TIME_W;
    localparam int OUT_BITS     = OUT_SAT_BIT + 1;
    localparam int OUT_DATA_W   = ((OUT_BITS + 7) / 8) * 8;

    // Accumulation modes; the unused code behaves as running minimum
    localparam logic [MODE_W-1:0] MODE_INTEGRAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MAX      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MIN      = 2'd2;

    // Item kinds carried on tuser
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_RESET  = 1'b1;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [TIME_W-1:0]  time_t;
    typedef logic [DUR_W-1:0]   dur_t;
    typedef logic [IDX_W-1:0]   idx_t;

endpackage

// ===== src/twa_serial_mul.sv =====
// ----------------------------------------------------------------------------
// twa_serial_mul
// Bit-serial unsigned multiplier: one multiplier bit per cycle, shift-add.
// The multiplicand must hold steady while busy is high.
// ----------------------------------------------------------------------------
module twa_serial_mul #(
    parameter int A_W = 32,
    parameter int B_W = 48
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               busy,
    output logic [A_W+B_W-1:0] prod
);

    localparam int CNT_W = $clog2(A_W);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [B_W-1:0]   hi_reg;
    logic [A_W-1:0]   lo_reg;
    logic [B_W:0]     sum;

    // Add the multiplicand when the current multiplier bit is set
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, b} : '0);

    // Count A_W steps after start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CNT_W'(A_W - 1))
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Shift the partial product right; product bits fill the multiplier register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hi_reg <= '0;
            lo_reg <= a;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[B_W:1];
            lo_reg <= {sum[0], lo_reg[A_W-1:1]};
        end
    end

    assign busy = busy_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

// ===== src/twa_serial_div.sv =====
// ----------------------------------------------------------------------------
// twa_serial_div
// Restoring radix-2 divider: one quotient bit per cycle.  The numerator's
// upper D_W bits must be below the divisor; the divisor holds while busy.
// ----------------------------------------------------------------------------
module twa_serial_div #(
    parameter int Q_W = 32,
    parameter int D_W = 49
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [Q_W+D_W-1:0] num,
    input  logic [D_W-1:0]     den,
    output logic               busy,
    output logic [Q_W-1:0]     quot
);

    localparam int CNT_W = $clog2(Q_W);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [D_W-1:0]   rem_reg;
    logic [Q_W-1:0]   qr_reg;
    logic [D_W:0]     trial;
    logic [D_W+1:0]   diff;
    logic             fits;

    // Bring down the next numerator bit and try the subtraction
    assign trial = {rem_reg, qr_reg[Q_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, den};
    assign fits  = !diff[D_W+1];

    // Count Q_W steps after start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CNT_W'(Q_W - 1))
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Keep the remainder; quotient bits shift in behind the numerator bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[Q_W+D_W-1:Q_W];
            qr_reg  <= num[Q_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
            qr_reg  <= {qr_reg[Q_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quot = qr_reg;

endmodule

// ===== src/twa_cell_store.sv =====
// ----------------------------------------------------------------------------
// twa_cell_store
// Per-cell memory: written mark and value, one write and one registered read.
// ----------------------------------------------------------------------------
module twa_cell_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 33
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] cells_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cells_reg[waddr] <= wdata;
        end
        rdata_reg <= cells_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/time_weighted_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// time_weighted_accumulator_core
// Per-cell time-weighted mean, running maximum or running minimum of signed
// Q16.16 samples, with a saturating total of accumulated time.
// ----------------------------------------------------------------------------
// One item is worked at a time and each gives one result word. In integral
// mode two bit-serial multipliers form old*T and sample*d side by side, one
// bit per cycle, and a restoring divider produces the mean one quotient bit
// per cycle. Maximum and minimum samples, zero-duration samples and
// out-of-range indexes skip the multiply and divide. A reset item sweeps the
// written marks out of the cell memory one entry a cycle; the same sweep
// runs after rst_n, with s_axis_tready low. The next item is accepted while
// a finished result waits on the master side. accumulation_mode is written
// through cfg_wr_en/cfg_wr_data; the user must do so only while idle, as the
// block itself does not enforce it.
// ----------------------------------------------------------------------------
module time_weighted_accumulator_core #(
    parameter int CELL_COUNT = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Slave side
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [twa_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // cell_index, sample_value, step_duration
    input  logic [0:0]                     s_axis_tuser,  // op
    input  logic                           s_axis_tlast,  // end_of_step
    // Master side
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [twa_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // out_index, accumulated_value,
                                                          // accumulated_time, time_saturated
    // Configuration
    input  logic                           cfg_wr_en,
    input  logic [twa_pkg::MODE_W-1:0]     cfg_wr_data    // accumulation_mode
);

    localparam int VW     = twa_pkg::VALUE_W;
    localparam int TW     = twa_pkg::TIME_W;
    localparam int DW     = twa_pkg::DUR_W;
    localparam int IW     = twa_pkg::IDX_W;
    localparam int ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int PA_W   = VW + TW;
    localparam int PB_W   = VW + DW;
    localparam int NUM_W  = PA_W + 1;
    localparam int DEN_W  = TW + 1;

    localparam logic [TW-1:0]     TIME_MAX  = '1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DECIDE,
        S_MUL,
        S_COMB,
        S_SIGN,
        S_DIV,
        S_NEG,
        S_TIME,
        S_EMIT
    } state_t;

    // Control registers
    state_t                         state_reg, state_next;
    logic [twa_pkg::MODE_W-1:0]     mode_reg, mode_next;
    twa_pkg::time_t                 total_reg, total_next;
    logic [ADDR_W-1:0]              sweep_reg, sweep_next;
    logic                           emit_after_clear_reg, emit_after_clear_next;
    logic                           out_valid_reg, out_valid_next;
    logic [twa_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // Datapath registers
    twa_pkg::idx_t   idx_reg;
    twa_pkg::value_t smp_reg;
    twa_pkg::dur_t   dur_reg;
    logic            eos_reg;
    twa_pkg::value_t res_value_reg;
    logic [DEN_W-1:0] den_reg;
    logic            old_neg_reg;
    logic            smp_neg_reg;
    logic [NUM_W:0]  r_reg;
    logic            neg_reg;

    // Memory port
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [VW:0]       mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [VW:0]       mem_rdata;

    // Arithmetic units
    logic              mul_start;
    logic              mul_t_busy;
    logic              mul_d_busy;
    logic [PA_W-1:0]   prod_t;
    logic [PB_W-1:0]   prod_d;
    logic              div_start;
    logic              div_busy;
    twa_pkg::value_t   quot;

    // Combinational helpers
    logic              in_accept;
    logic              in_range;
    logic              cell_written;
    twa_pkg::value_t   old_val;
    twa_pkg::value_t   old_mag;
    twa_pkg::value_t   smp_mag;
    logic              smp_gt;
    twa_pkg::value_t   minmax_val;
    logic              do_update;
    logic [DEN_W-1:0]  time_sum;
    logic              time_sat;
    logic              same_sign;
    logic [NUM_W:0]    pa_x;
    logic [NUM_W:0]    pb_x;
    logic [NUM_W:0]    r_next;
    logic              r_flip;
    logic [NUM_W-1:0]  num_mag;
    twa_pkg::value_t   mean_val;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Look up the current cell
    assign mem_raddr    = ADDR_W'(idx_reg);
    assign in_range     = 32'(idx_reg) < 32'(CELL_COUNT);
    assign cell_written = mem_rdata[VW] && in_range;
    assign old_val      = cell_written ? mem_rdata[VW-1:0] : '0;
    assign old_mag      = old_val[VW-1] ? (VW'(0) - old_val) : old_val;
    assign smp_mag      = smp_reg[VW-1] ? (VW'(0) - smp_reg) : smp_reg;
    assign do_update    = (dur_reg != '0) && in_range;

    // Running maximum / minimum
    assign smp_gt = $signed(smp_reg) > $signed(old_val);
    always_comb
    begin
        if (!cell_written)
        begin
            minmax_val = smp_reg;
        end
        else if (mode_reg == twa_pkg::MODE_MAX)
        begin
            minmax_val = smp_gt ? smp_reg : old_val;
        end
        else
        begin
            minmax_val = smp_gt ? old_val : smp_reg;
        end
    end

    // Total time plus duration: divisor of the mean and saturating update
    assign time_sum = {1'b0, total_reg} + DEN_W'(dur_reg);
    assign time_sat = time_sum[TW] || (time_sum[TW-1:0] == TIME_MAX);

    // Combine the signed products into a magnitude and a sign
    assign same_sign = (old_neg_reg == smp_neg_reg);
    assign pa_x      = (NUM_W + 1)'(prod_t);
    assign pb_x      = (NUM_W + 1)'(prod_d);
    assign r_next    = same_sign ? (pa_x + pb_x) : (pa_x - pb_x);
    assign r_flip    = !same_sign && r_reg[NUM_W];
    assign num_mag   = r_flip ? NUM_W'((NUM_W + 1)'(0) - r_reg) : r_reg[NUM_W-1:0];
    assign mean_val  = neg_reg ? (VW'(0) - quot) : quot;

    assign mul_start = (state_reg == S_DECIDE) && do_update
                       && (mode_reg == twa_pkg::MODE_INTEGRAL);
    assign div_start = (state_reg == S_SIGN);

    // Memory writes: clearing sweep, max/min update, mean update
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ADDR_W'(idx_reg);
        mem_wdata = {1'b1, minmax_val};
        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                mem_wdata = '0;
            end
            S_DECIDE:
            begin
                mem_we = do_update && (mode_reg != twa_pkg::MODE_INTEGRAL);
            end
            S_NEG:
            begin
                mem_we    = 1'b1;
                mem_wdata = {1'b1, mean_val};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next            = state_reg;
        mode_next             = cfg_wr_en ? cfg_wr_data : mode_reg;
        total_next            = total_reg;
        sweep_next            = sweep_reg;
        emit_after_clear_next = emit_after_clear_reg;
        out_valid_next        = out_valid_reg && !m_axis_tready;
        out_data_next         = out_data_reg;
        case (state_reg)
            S_CLEAR:
            begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_ADDR)
                begin
                    sweep_next            = '0;
                    emit_after_clear_next = 1'b0;
                    state_next            = emit_after_clear_reg ? S_EMIT : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_axis_tuser[0] == twa_pkg::OP_RESET)
                    begin
                        total_next            = '0;
                        sweep_next            = '0;
                        emit_after_clear_next = 1'b1;
                        state_next            = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = mul_start ? S_MUL : S_TIME;
            end
            S_MUL:
            begin
                if (!mul_t_busy && !mul_d_busy)
                begin
                    state_next = S_COMB;
                end
            end
            S_COMB:
            begin
                state_next = S_SIGN;
            end
            S_SIGN:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = S_NEG;
                end
            end
            S_NEG:
            begin
                state_next = S_TIME;
            end
            S_TIME:
            begin
                if ((dur_reg != '0) && eos_reg)
                begin
                    total_next = time_sat ? TIME_MAX : time_sum[TW-1:0];
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = twa_pkg::OUT_DATA_W'({(total_reg == TIME_MAX),
                                                           total_reg, res_value_reg,
                                                           idx_reg});
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, configuration, total time and the output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_CLEAR;
            mode_reg             <= twa_pkg::MODE_INTEGRAL;
            total_reg            <= '0;
            sweep_reg            <= '0;
            emit_after_clear_reg <= 1'b0;
            out_valid_reg        <= 1'b0;
            out_data_reg         <= '0;
        end
        else
        begin
            state_reg            <= state_next;
            mode_reg             <= mode_next;
            total_reg            <= total_next;
            sweep_reg            <= sweep_next;
            emit_after_clear_reg <= emit_after_clear_next;
            out_valid_reg        <= out_valid_next;
            out_data_reg         <= out_data_next;
        end
    end

    // Capture the item and the intermediate results
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            idx_reg       <= s_axis_tdata[twa_pkg::IN_IDX_LSB +: IW];
            smp_reg       <= s_axis_tdata[twa_pkg::IN_SMP_LSB +: VW];
            dur_reg       <= s_axis_tdata[twa_pkg::IN_DUR_LSB +: DW];
            eos_reg       <= s_axis_tlast;
            res_value_reg <= '0;
        end
        if (state_reg == S_DECIDE)
        begin
            den_reg     <= time_sum;
            old_neg_reg <= old_val[VW-1];
            smp_neg_reg <= smp_reg[VW-1];
            if (!do_update)
            begin
                res_value_reg <= old_val;
            end
            else if (mode_reg != twa_pkg::MODE_INTEGRAL)
            begin
                res_value_reg <= minmax_val;
            end
        end
        if (state_reg == S_COMB)
        begin
            r_reg <= r_next;
        end
        if (state_reg == S_SIGN)
        begin
            neg_reg <= r_flip ? smp_neg_reg : old_neg_reg;
        end
        if (state_reg == S_NEG)
        begin
            res_value_reg <= mean_val;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    twa_cell_store #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (ADDR_W),
        .DATA_W (VW + 1)
    ) u_cell_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    twa_serial_mul #(
        .A_W (VW),
        .B_W (TW)
    ) u_mul_time (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (old_mag),
        .b     (total_reg),
        .busy  (mul_t_busy),
        .prod  (prod_t)
    );

    twa_serial_mul #(
        .A_W (VW),
        .B_W (DW)
    ) u_mul_dur (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (smp_mag),
        .b     (dur_reg),
        .busy  (mul_d_busy),
        .prod  (prod_d)
    );

    twa_serial_div #(
        .Q_W (VW),
        .D_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_mag),
        .den   (den_reg),
        .busy  (div_busy),
        .quot  (quot)
    );

endmodule

// ===== src/twa_checker.sv =====
// ----------------------------------------------------------------------------
// twa_checker
// Port-level checks of the time-weighted accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module twa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [twa_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // One word in flight: ready drops right after an accepted word
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted on two consecutive cycles");

    // A result never appears on the cycle right after its word was taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
        else $error("result appeared too early");

    // Saturation flag agrees with an all-ones total time
    a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[twa_pkg::OUT_SAT_BIT]
            == (&m_axis_tdata[twa_pkg::OUT_SAT_BIT-1:twa_pkg::OUT_TIME_LSB])))
        else $error("time_saturated disagrees with accumulated_time");

    // Pad bits above the result fields stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[twa_pkg::OUT_DATA_W-1:twa_pkg::OUT_BITS] == '0))
        else $error("pad bits set in result word");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result word changed while stalled");

endmodule

bind time_weighted_accumulator_core twa_checker u_twa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
